// File: rtl/core/sc1d_pkg.sv
// Shared constants, codes and types of the strided 1-D convolution engine.
// Used by sc1d_seq, sc1d_mac and strided_conv1d_engine; depends on nothing else.

package sc1d_pkg;

    // Sizing of the stores and datapath
    localparam int MAX_CHANNELS = 4;
    localparam int MAX_KERNEL   = 8;
    localparam int MAX_LENGTH   = 16;
    localparam int VALUE_WIDTH  = 16;

    localparam int WST_DEPTH = MAX_CHANNELS * MAX_CHANNELS * MAX_KERNEL;
    localparam int SST_DEPTH = MAX_CHANNELS * MAX_LENGTH;
    localparam int WA_W      = $clog2(WST_DEPTH);
    localparam int SA_W      = $clog2(SST_DEPTH);
    localparam int CH_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int TAP_W     = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int POS_W     = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int FILL_W    = $clog2(SST_DEPTH + 1);

    // Fixed field and register widths
    localparam int CC_W    = 3;
    localparam int KL_W    = 4;
    localparam int IL_W    = 5;
    localparam int WS_W    = 4;
    localparam int F_OC_W  = 2;
    localparam int F_IC_W  = 2;
    localparam int F_TAP_W = 3;
    localparam int WIN_W   = 4;
    localparam int BATCH_W = 16;
    localparam int SUM_W   = 40;
    localparam int PROD_W  = 2 * VALUE_WIDTH;
    localparam int ADDR_W  = 4;
    localparam int APB_W   = 32;

    // Window start plus one stride, never beyond the longest input plus stride
    localparam int ST_W = $clog2(MAX_LENGTH + (1 << WS_W)) + 1;

    // Stream packing
    localparam int IN_OC_LSB   = 0;
    localparam int IN_IC_LSB   = IN_OC_LSB + F_OC_W;
    localparam int IN_TAP_LSB  = IN_IC_LSB + F_IC_W;
    localparam int IN_VAL_LSB  = IN_TAP_LSB + F_TAP_W;
    localparam int IN_DATA_W   = ((IN_VAL_LSB + VALUE_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((SUM_W + F_OC_W + WIN_W + BATCH_W + 7) / 8) * 8;

    // Request kinds
    localparam logic REQ_WEIGHT = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // Register indexes
    localparam logic [1:0] REG_CHANNELS = 2'd0;
    localparam logic [1:0] REG_KERNEL   = 2'd1;
    localparam logic [1:0] REG_LENGTH   = 2'd2;
    localparam logic [1:0] REG_STRIDE   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RECALC,
        ST_WAIT,
        ST_ISSUE,
        ST_DRAIN
    } seq_state_t;

    // Effective (saturated) configuration
    typedef struct packed {
        logic [CC_W-1:0] c;
        logic [KL_W-1:0] k;
        logic [IL_W-1:0] l;
        logic [WS_W-1:0] s;
    } run_cfg_t;

    // Tag that follows each store read down the MAC pipeline
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             fin;
        logic             err;
        logic             last;
        logic [CH_W-1:0]  oc;
        logic [WIN_W-1:0] win;
    } mac_tag_t;

    typedef struct packed {
        logic busy;
        logic out_full;
        logic load;
    } mac_stat_t;

endpackage

// File: rtl/core/sc1d_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.

module sc1d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/sc1d_seq.sv
// Sequencer: takes input beats, fills the sample store, writes weights and
// walks output channel, window, input channel and tap during a run.
// Depends on sc1d_pkg.

module sc1d_seq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           in_type,
    input  logic [sc1d_pkg::F_OC_W-1:0]    in_oc,
    input  logic [sc1d_pkg::F_IC_W-1:0]    in_ic,
    input  logic [sc1d_pkg::F_TAP_W-1:0]   in_tap,
    input  logic [sc1d_pkg::VALUE_WIDTH-1:0] in_value,
    input  sc1d_pkg::run_cfg_t             cfg,
    input  logic                           cfg_wr,
    input  sc1d_pkg::mac_stat_t            stat,
    output logic                           w_we,
    output logic [sc1d_pkg::WA_W-1:0]      w_waddr,
    output logic                           s_we,
    output logic [sc1d_pkg::SA_W-1:0]      s_waddr,
    output logic [sc1d_pkg::VALUE_WIDTH-1:0] wdata,
    output logic [sc1d_pkg::WA_W-1:0]      w_raddr,
    output logic [sc1d_pkg::SA_W-1:0]      s_raddr,
    output sc1d_pkg::mac_tag_t             tag,
    output logic [sc1d_pkg::BATCH_W-1:0]   batch
);

    import sc1d_pkg::*;

    seq_state_t        state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] rem_reg, rem_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              err_reg, err_next;
    logic [BATCH_W-1:0] batch_reg, batch_next;
    logic [CH_W-1:0]   oc_reg, oc_next;
    logic [CH_W-1:0]   ic_reg, ic_next;
    logic [TAP_W-1:0]  t_reg, t_next;
    logic [WIN_W-1:0]  win_reg, win_next;
    logic [ST_W-1:0]   start_reg, start_next;

    logic [FILL_W-1:0] total;
    logic              restart;
    logic [FILL_W-1:0] fill_eff;
    logic [FILL_W-1:0] fill_inc;
    logic [CH_W-1:0]   ch_eff;
    logic [POS_W-1:0]  pos_eff;
    logic              pos_wrap;
    logic              complete;
    logic              accept;
    logic              push;
    logic              rem_ge_l;
    logic              last_t;
    logic              last_ic;
    logic              last_oc;
    logic              sum_fin;
    logic [ST_W-1:0]   start_step;
    logic              win_end;

    assign total      = FILL_W'(int'(cfg.c) * int'(cfg.l));
    assign restart    = fill_reg >= total;
    assign fill_eff   = restart ? '0 : fill_reg;
    assign ch_eff     = restart ? '0 : ch_reg;
    assign pos_eff    = restart ? '0 : pos_reg;
    assign fill_inc   = fill_eff + FILL_W'(1);
    assign complete   = fill_inc >= total;
    assign pos_wrap   = (int'(pos_eff) + 1) == int'(cfg.l);
    assign rem_ge_l   = int'(rem_reg) >= int'(cfg.l);

    assign last_t     = (int'(t_reg) + 1) == int'(cfg.k);
    assign last_ic    = (int'(ic_reg) + 1) == int'(cfg.c);
    assign last_oc    = (int'(oc_reg) + 1) == int'(cfg.c);
    assign sum_fin    = last_t && last_ic;
    assign start_step = start_reg + ST_W'(cfg.s);
    assign win_end    = (int'(start_step) + int'(cfg.k)) > int'(cfg.l);

    assign batch   = batch_reg;
    assign w_waddr = WA_W'(int'(in_oc) * (MAX_CHANNELS * MAX_KERNEL)
                           + int'(in_ic) * MAX_KERNEL + int'(in_tap));
    assign s_waddr = SA_W'(int'(ch_eff) * MAX_LENGTH + int'(pos_eff));
    assign wdata   = in_value;
    assign w_raddr = WA_W'(int'(oc_reg) * (MAX_CHANNELS * MAX_KERNEL)
                           + int'(ic_reg) * MAX_KERNEL + int'(t_reg));
    assign s_raddr = SA_W'(int'(ic_reg) * MAX_LENGTH + int'(start_reg) + int'(t_reg));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_wr)
                begin
                    state_next = ST_RECALC;
                end
                else if (push && complete)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_RECALC:
            begin
                if (cfg_wr)
                begin
                    state_next = ST_RECALC;
                end
                else if (restart || !rem_ge_l)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WAIT:
            begin
                if (!stat.busy && !stat.out_full)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (err_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else if (sum_fin)
                begin
                    state_next = (last_oc && win_end) ? ST_DRAIN : ST_WAIT;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready = (state_reg == ST_IDLE) && !cfg_wr;
        accept   = in_valid && in_ready;
        push     = accept && (in_type == REQ_SAMPLE);
        w_we     = accept && (in_type == REQ_WEIGHT)
                   && (int'(in_oc) < MAX_CHANNELS) && (int'(in_ic) < MAX_CHANNELS)
                   && (int'(in_tap) < MAX_KERNEL);
        s_we     = push;
        tag      = '0;
        if (state_reg == ST_ISSUE)
        begin
            tag.valid = 1'b1;
            tag.err   = err_reg;
            tag.first = err_reg || ((ic_reg == '0) && (t_reg == '0));
            tag.fin   = err_reg || sum_fin;
            tag.last  = err_reg || (sum_fin && last_oc && win_end);
            tag.oc    = oc_reg;
            tag.win   = win_reg;
        end
    end

    // Counters
    always_comb
    begin
        fill_next  = fill_reg;
        rem_next   = rem_reg;
        ch_next    = ch_reg;
        pos_next   = pos_reg;
        err_next   = err_reg;
        batch_next = batch_reg;
        oc_next    = oc_reg;
        ic_next    = ic_reg;
        t_next     = t_reg;
        win_next   = win_reg;
        start_next = start_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_wr)
                begin
                    rem_next = fill_reg;
                    ch_next  = '0;
                end
                else if (push)
                begin
                    if (complete)
                    begin
                        fill_next  = '0;
                        ch_next    = '0;
                        pos_next   = '0;
                        err_next   = int'(cfg.k) > int'(cfg.l);
                        oc_next    = '0;
                        ic_next    = '0;
                        t_next     = '0;
                        win_next   = '0;
                        start_next = '0;
                    end
                    else
                    begin
                        fill_next = fill_inc;
                        if (pos_wrap)
                        begin
                            pos_next = '0;
                            ch_next  = ch_eff + CH_W'(1);
                        end
                        else
                        begin
                            pos_next = pos_eff + POS_W'(1);
                            ch_next  = ch_eff;
                        end
                    end
                end
            end
            ST_RECALC:
            begin
                // Rebuild channel and position from the fill after a configuration write
                if (cfg_wr)
                begin
                    rem_next = fill_reg;
                    ch_next  = '0;
                end
                else if (restart)
                begin
                    ch_next  = '0;
                    pos_next = '0;
                end
                else if (rem_ge_l)
                begin
                    rem_next = rem_reg - FILL_W'(cfg.l);
                    ch_next  = ch_reg + CH_W'(1);
                end
                else
                begin
                    pos_next = POS_W'(rem_reg);
                end
            end
            ST_ISSUE:
            begin
                if (!err_reg)
                begin
                    if (last_t)
                    begin
                        t_next = '0;
                        if (last_ic)
                        begin
                            ic_next = '0;
                            if (win_end)
                            begin
                                start_next = '0;
                                win_next   = '0;
                                oc_next    = oc_reg + CH_W'(1);
                            end
                            else
                            begin
                                start_next = start_step;
                                win_next   = win_reg + WIN_W'(1);
                            end
                        end
                        else
                        begin
                            ic_next = ic_reg + CH_W'(1);
                        end
                    end
                    else
                    begin
                        t_next = t_reg + TAP_W'(1);
                    end
                end
            end
            ST_DRAIN:
            begin
                if (!stat.busy)
                begin
                    batch_next = batch_reg + BATCH_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            rem_reg   <= '0;
            ch_reg    <= '0;
            pos_reg   <= '0;
            err_reg   <= 1'b0;
            batch_reg <= '0;
            oc_reg    <= '0;
            ic_reg    <= '0;
            t_reg     <= '0;
            win_reg   <= '0;
            start_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            rem_reg   <= rem_next;
            ch_reg    <= ch_next;
            pos_reg   <= pos_next;
            err_reg   <= err_next;
            batch_reg <= batch_next;
            oc_reg    <= oc_next;
            ic_reg    <= ic_next;
            t_reg     <= t_next;
            win_reg   <= win_next;
            start_reg <= start_next;
        end
    end

endmodule

// File: rtl/core/sc1d_mac.sv
// Multiply-accumulate pipeline behind the two stores, and the output register.
// Depends on sc1d_pkg.

module sc1d_mac (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sc1d_pkg::mac_tag_t               tag,
    input  logic [sc1d_pkg::VALUE_WIDTH-1:0] w_rdata,
    input  logic [sc1d_pkg::VALUE_WIDTH-1:0] s_rdata,
    input  logic [sc1d_pkg::BATCH_W-1:0]     batch,
    input  logic                             out_ready,
    output sc1d_pkg::mac_stat_t              stat,
    output logic                             out_valid,
    output logic [sc1d_pkg::SUM_W-1:0]       out_sum,
    output logic [sc1d_pkg::F_OC_W-1:0]      out_oc,
    output logic [sc1d_pkg::WIN_W-1:0]       out_win,
    output logic [sc1d_pkg::BATCH_W-1:0]     out_batch,
    output logic                             out_status,
    output logic                             out_last
);

    import sc1d_pkg::*;

    mac_tag_t                 t1_reg, t2_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [SUM_W-1:0]         acc_reg, acc_sum;
    logic                     out_valid_reg, out_valid_next;
    logic                     load;

    assign prod_next = $signed(w_rdata) * $signed(s_rdata);
    assign acc_sum   = (t2_reg.first ? '0 : acc_reg) + SUM_W'(prod_reg);
    assign load      = t2_reg.valid && t2_reg.fin;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign stat.busy     = t1_reg.valid || t2_reg.valid;
    assign stat.out_full = out_valid_reg;
    assign stat.load     = load;
    assign out_valid     = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg        <= '0;
            t2_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            t1_reg        <= tag;
            t2_reg        <= t1_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: product, running sum and result fields
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (t2_reg.valid)
        begin
            acc_reg <= acc_sum;
        end
        if (load)
        begin
            out_batch  <= batch;
            out_status <= t2_reg.err;
            out_last   <= t2_reg.last;
            if (t2_reg.err)
            begin
                out_sum <= '0;
                out_oc  <= '0;
                out_win <= '0;
            end
            else
            begin
                out_sum <= acc_sum;
                out_oc  <= F_OC_W'(t2_reg.oc);
                out_win <= t2_reg.win;
            end
        end
    end

endmodule

// File: rtl/core/strided_conv1d_engine.sv
// Top level of the strided multichannel 1-D convolution engine: stream and
// APB ports, configuration registers, stores. Depends on sc1d_pkg, sc1d_ram,
// sc1d_seq and sc1d_mac.

// A weight write or a sample push that does not end a batch item leaves input
// ready unless a configuration write is under way. The push that ends the item
// starts a run on the single shared multiply-accumulate: each output is summed
// over C*K products (one weight-store read and one sample-store read per cycle),
// and before each output the sequencer waits for the pipeline to empty and the
// output register to be taken, so input is held off after that push until all
// C*W results for W windows are summed, longer while the output is stalled; a
// run where the kernel is longer than the input gives one error result. After
// a configuration write, input is held while the sample position is rebuilt.
// The stores come up undefined; there is no clearing pass.
// Registers: channel_count at 0x0, kernel_length at 0x4, input_length at 0x8,
// window_stride at 0xC.

module strided_conv1d_engine (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // weight_out_channel, weight_in_channel, weight_tap, data_value, zero pad
    input  logic [sc1d_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // req_type
    input  logic [0:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // conv_sum, out_channel, window_index, batch_index, zero pad
    output logic [sc1d_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // status
    output logic [0:0]                       m_axis_tuser,
    output logic                             m_axis_tlast,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sc1d_pkg::ADDR_W-1:0]      paddr,
    input  logic [sc1d_pkg::APB_W-1:0]       pwdata,
    output logic [sc1d_pkg::APB_W-1:0]       prdata,
    output logic                             pready
);

    import sc1d_pkg::*;

    logic [CC_W-1:0] cc_reg, cc_next;
    logic [KL_W-1:0] kl_reg, kl_next;
    logic [IL_W-1:0] il_reg, il_next;
    logic [WS_W-1:0] ws_reg, ws_next;
    logic            cfg_wr;
    run_cfg_t        cfg;

    logic                   w_we, s_we;
    logic [WA_W-1:0]        w_waddr, w_raddr;
    logic [SA_W-1:0]        s_waddr, s_raddr;
    logic [VALUE_WIDTH-1:0] wdata, w_rdata, s_rdata;
    mac_tag_t               tag;
    mac_stat_t              mac_stat;
    logic [BATCH_W-1:0]     batch;
    logic [SUM_W-1:0]       out_sum;
    logic [F_OC_W-1:0]      out_oc;
    logic [WIN_W-1:0]       out_win;
    logic [BATCH_W-1:0]     out_batch;
    logic                   out_status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        cc_next = cc_reg;
        kl_next = kl_reg;
        il_next = il_reg;
        ws_next = ws_reg;
        if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_CHANNELS: cc_next = pwdata[CC_W-1:0];
                REG_KERNEL:   kl_next = pwdata[KL_W-1:0];
                REG_LENGTH:   il_next = pwdata[IL_W-1:0];
                REG_STRIDE:   ws_next = pwdata[WS_W-1:0];
                default:      cc_next = cc_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_CHANNELS: prdata = APB_W'(cc_reg);
            REG_KERNEL:   prdata = APB_W'(kl_reg);
            REG_LENGTH:   prdata = APB_W'(il_reg);
            REG_STRIDE:   prdata = APB_W'(ws_reg);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg <= CC_W'(1);
            kl_reg <= KL_W'(1);
            il_reg <= IL_W'(16);
            ws_reg <= WS_W'(1);
        end
        else
        begin
            cc_reg <= cc_next;
            kl_reg <= kl_next;
            il_reg <= il_next;
            ws_reg <= ws_next;
        end
    end

    // Saturate to the supported ranges; a zero stride steps by one
    always_comb
    begin
        cfg.c = (cc_reg == '0) ? CC_W'(1)
              : ((int'(cc_reg) > MAX_CHANNELS) ? CC_W'(MAX_CHANNELS) : cc_reg);
        cfg.k = (kl_reg == '0) ? KL_W'(1)
              : ((int'(kl_reg) > MAX_KERNEL) ? KL_W'(MAX_KERNEL) : kl_reg);
        cfg.l = (il_reg == '0) ? IL_W'(1)
              : ((int'(il_reg) > MAX_LENGTH) ? IL_W'(MAX_LENGTH) : il_reg);
        cfg.s = (ws_reg == '0) ? WS_W'(1) : ws_reg;
    end

    sc1d_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_type  (s_axis_tuser[0]),
        .in_oc    (s_axis_tdata[IN_OC_LSB +: F_OC_W]),
        .in_ic    (s_axis_tdata[IN_IC_LSB +: F_IC_W]),
        .in_tap   (s_axis_tdata[IN_TAP_LSB +: F_TAP_W]),
        .in_value (s_axis_tdata[IN_VAL_LSB +: VALUE_WIDTH]),
        .cfg      (cfg),
        .cfg_wr   (cfg_wr),
        .stat     (mac_stat),
        .w_we     (w_we),
        .w_waddr  (w_waddr),
        .s_we     (s_we),
        .s_waddr  (s_waddr),
        .wdata    (wdata),
        .w_raddr  (w_raddr),
        .s_raddr  (s_raddr),
        .tag      (tag),
        .batch    (batch)
    );

    sc1d_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (WST_DEPTH)
    ) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (wdata),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    sc1d_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (SST_DEPTH)
    ) u_sample_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    sc1d_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .tag        (tag),
        .w_rdata    (w_rdata),
        .s_rdata    (s_rdata),
        .batch      (batch),
        .out_ready  (m_axis_tready),
        .stat       (mac_stat),
        .out_valid  (m_axis_tvalid),
        .out_sum    (out_sum),
        .out_oc     (out_oc),
        .out_win    (out_win),
        .out_batch  (out_batch),
        .out_status (out_status),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata    = OUT_DATA_W'({out_batch, out_win, out_oc, out_sum});
    assign m_axis_tuser[0] = out_status;

    // Input is only taken with the MAC pipeline empty
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !mac_stat.busy)
        else $error("input beat taken while the MAC pipeline is busy");

    // A finished sum never lands on a result still waiting to be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        mac_stat.load |-> !(m_axis_tvalid && !m_axis_tready))
        else $error("finished sum overwrote a pending result");

    // The no-window result closes its run and carries a zero sum
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tlast && (out_sum == '0)))
        else $error("error result without last or with non-zero sum");

endmodule

// File: tb/conv1d_monitor.sv
// Monitor for the strided 1-D convolution engine: tracks APB register writes and
// input beats, predicts every output beat and compares it field by field.
// Depends on sc1d_pkg for widths, packing offsets and codes.

module conv1d_monitor
    import sc1d_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    // weight_out_channel, weight_in_channel, weight_tap, data_value, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // req_type
    input  logic [0:0]            s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // conv_sum, out_channel, window_index, batch_index, zero pad
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    // status
    input  logic [0:0]            m_axis_tuser,
    input  logic                  m_axis_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [APB_W-1:0]      pwdata,
    input  logic                  pready,
    output int unsigned           mismatches,
    output int unsigned           outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OUT_OC_LSB    = SUM_W;
    localparam int OUT_WIN_LSB   = OUT_OC_LSB + F_OC_W;
    localparam int OUT_BATCH_LSB = OUT_WIN_LSB + WIN_W;

    typedef struct {
        logic [SUM_W-1:0]   sum;
        logic [F_OC_W-1:0]  oc;
        logic [WIN_W-1:0]   win;
        logic [BATCH_W-1:0] batch;
        logic               status;
        logic               last;
    } conv_out_t;

    conv_out_t sums_due[$];

    logic signed [VALUE_WIDTH-1:0] coeff   [WST_DEPTH];
    logic signed [VALUE_WIDTH-1:0] samples [SST_DEPTH];
    int unsigned                   fill_pos;
    logic [BATCH_W-1:0]            batch_no;
    logic [CC_W-1:0]               reg_c;
    logic [KL_W-1:0]               reg_k;
    logic [IL_W-1:0]               reg_l;
    logic [WS_W-1:0]               reg_s;

    function automatic int unsigned bound(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Queue every window sum of one completed batch item
    function automatic void compute_windows(int unsigned c, int unsigned k,
                                            int unsigned l, int unsigned s);
        int unsigned        start;
        int unsigned        win;
        logic signed [39:0] acc;
        logic signed [31:0] prod;
        conv_out_t          r;
        r.batch  = batch_no;
        r.status = 1'b0;
        r.last   = 1'b0;
        if (k > l)
        begin
            r.sum    = '0;
            r.oc     = '0;
            r.win    = '0;
            r.status = 1'b1;
            r.last   = 1'b1;
            sums_due.push_back(r);
            return;
        end
        for (int unsigned oc = 0; oc < c; oc++)
        begin
            win = 0;
            for (start = 0; start + k <= l; start += s)
            begin
                acc = '0;
                for (int unsigned ic = 0; ic < c; ic++)
                    for (int unsigned t = 0; t < k; t++)
                    begin
                        prod = coeff[oc * MAX_CHANNELS * MAX_KERNEL + ic * MAX_KERNEL + t]
                             * samples[ic * MAX_LENGTH + start + t];
                        acc = acc + {{8{prod[31]}}, prod};
                    end
                r.sum = acc;
                r.oc  = oc[F_OC_W-1:0];
                r.win = win[WIN_W-1:0];
                sums_due.push_back(r);
                win++;
            end
        end
        sums_due[sums_due.size() - 1].last = 1'b1;
    endfunction

    function automatic void take_beat(logic kind, logic [IN_DATA_W-1:0] d);
        int unsigned c;
        int unsigned k;
        int unsigned l;
        int unsigned s;
        int unsigned total;
        int unsigned oc;
        int unsigned ic;
        int unsigned tap;
        logic signed [VALUE_WIDTH-1:0] v;
        c     = bound(reg_c, MAX_CHANNELS);
        k     = bound(reg_k, MAX_KERNEL);
        l     = bound(reg_l, MAX_LENGTH);
        s     = (reg_s == 0) ? 1 : reg_s;
        total = c * l;
        v     = d[IN_VAL_LSB +: VALUE_WIDTH];
        if (kind == REQ_WEIGHT)
        begin
            oc  = d[IN_OC_LSB +: F_OC_W];
            ic  = d[IN_IC_LSB +: F_IC_W];
            tap = d[IN_TAP_LSB +: F_TAP_W];
            coeff[oc * MAX_CHANNELS * MAX_KERNEL + ic * MAX_KERNEL + tap] = v;
            return;
        end
        // restart the item when a smaller setting leaves the fill past its end
        if (fill_pos >= total)
            fill_pos = 0;
        samples[(fill_pos / l) * MAX_LENGTH + (fill_pos % l)] = v;
        fill_pos++;
        if (fill_pos < total)
            return;
        compute_windows(c, k, l, s);
        fill_pos = 0;
        batch_no = batch_no + 1'b1;
    endfunction

    function automatic int unsigned differs(string field, logic [63:0] want, logic [63:0] got);
        if (got === want)
            return 0;
        $error("%s: expected 'h%0h, got 'h%0h", field, want, got);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        int unsigned errs;
        conv_out_t   want;
        if (!rst_n)
        begin
            sums_due.delete();
            fill_pos = 0;
            batch_no = '0;
            reg_c    = 3'd1;
            reg_k    = 4'd1;
            reg_l    = 5'd16;
            reg_s    = 4'd1;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            errs = 0;
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_CHANNELS: reg_c = pwdata[CC_W-1:0];
                    REG_KERNEL:   reg_k = pwdata[KL_W-1:0];
                    REG_LENGTH:   reg_l = pwdata[IL_W-1:0];
                    REG_STRIDE:   reg_s = pwdata[WS_W-1:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (sums_due.size() == 0)
                begin
                    $error("result beat with nothing expected: tdata 'h%0h", m_axis_tdata);
                    errs++;
                end
                else
                begin
                    want = sums_due.pop_front();
                    errs += differs("conv_sum", want.sum, m_axis_tdata[SUM_W-1:0]);
                    errs += differs("out_channel", want.oc, m_axis_tdata[OUT_OC_LSB +: F_OC_W]);
                    errs += differs("window_index", want.win,
                                    m_axis_tdata[OUT_WIN_LSB +: WIN_W]);
                    errs += differs("batch_index", want.batch,
                                    m_axis_tdata[OUT_BATCH_LSB +: BATCH_W]);
                    errs += differs("status", want.status, m_axis_tuser[0]);
                    errs += differs("last", want.last, m_axis_tlast);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                take_beat(s_axis_tuser[0], s_axis_tdata);
            mismatches  <= mismatches + errs;
            outstanding <= sums_due.size();
        end
    end

endmodule

// File: tb/tb_top.sv
// Top of the strided 1-D convolution engine testbench: clock, reset, APB register
// writes, weight and sample beats, output back-pressure and the verdict.
// Depends on sc1d_pkg, strided_conv1d_engine and conv1d_monitor.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sc1d_pkg::*;

    localparam int unsigned ITEM_GOAL   = 170;
    localparam int unsigned SETTLE      = 16;
    localparam int unsigned TAIL        = 64;
    localparam int unsigned CYCLE_LIMIT = 500000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [0:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [APB_W-1:0]      pwdata;
    logic [APB_W-1:0]      prdata;
    logic                  pready;
    int unsigned           mismatches;
    int unsigned           outstanding;

    bit          burst;
    bit          wt_known [WST_DEPTH];
    int unsigned items_sent;
    int unsigned tb_fill;
    int unsigned cur_c;
    int unsigned cur_k;
    int unsigned cur_l;
    int unsigned cur_s;
    int unsigned sink_wait;
    int unsigned sink_beats;

    strided_conv1d_engine dut (.*);

    conv1d_monitor mon (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Output back-pressure: a random stall after each beat, with quiet stretches
    always @(posedge clk or negedge rst_n)
    begin : sink
        int unsigned d;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_wait     <= 0;
            sink_beats    <= 0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            d = (sink_beats % 32 < 8) ? 0 : $urandom_range(0, 7);
            sink_beats    <= sink_beats + 1;
            sink_wait     <= d;
            m_axis_tready <= (d == 0);
        end
        else if (sink_wait != 0)
        begin
            sink_wait     <= sink_wait - 1;
            m_axis_tready <= (sink_wait == 1);
        end
        else
            m_axis_tready <= 1'b1;
    end

    function automatic int unsigned saturate(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned item_size();
        return saturate(cur_c, MAX_CHANNELS) * saturate(cur_l, MAX_LENGTH);
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_beat(input logic kind, input logic [F_OC_W-1:0] oc,
                             input logic [F_IC_W-1:0] ic, input logic [F_TAP_W-1:0] tap,
                             input logic [VALUE_WIDTH-1:0] val);
        int unsigned gap;
        gap = burst ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {1'b0, val, tap, ic, oc};
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic write_weight(input int unsigned oc, input int unsigned ic,
                                input int unsigned tap, input logic [VALUE_WIDTH-1:0] val);
        send_beat(REQ_WEIGHT, oc[F_OC_W-1:0], ic[F_IC_W-1:0], tap[F_TAP_W-1:0], val);
        wt_known[oc * MAX_CHANNELS * MAX_KERNEL + ic * MAX_KERNEL + tap] = 1'b1;
    endtask

    task automatic write_random_weight();
        write_weight($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 7),
                     pick_value());
    endtask

    task automatic push_sample(input logic [VALUE_WIDTH-1:0] val);
        // the weight index fields are don't-care on a sample beat
        send_beat(REQ_SAMPLE, 2'($urandom()), 2'($urandom()), 3'($urandom()), val);
        tb_fill++;
        if (tb_fill == item_size())
            tb_fill = 0;
    endtask

    task automatic push_samples(input int unsigned n, input bit noisy);
        repeat (n)
        begin
            if (noisy && $urandom_range(0, 9) == 0)
                write_random_weight();
            push_sample(pick_value());
        end
    endtask

    // Fill every weight the current setting reads that has never been written
    task automatic ensure_weights();
        int unsigned c;
        int unsigned k;
        c = saturate(cur_c, MAX_CHANNELS);
        k = saturate(cur_k, MAX_KERNEL);
        for (int unsigned oc = 0; oc < c; oc++)
            for (int unsigned ic = 0; ic < c; ic++)
                for (int unsigned t = 0; t < k; t++)
                    if (!wt_known[oc * MAX_CHANNELS * MAX_KERNEL + ic * MAX_KERNEL + t])
                        write_weight(oc, ic, t, pick_value());
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input int unsigned val, input int unsigned w);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        // junk above the register width must be dropped
        pwdata  <= (32'($urandom()) << w) | 32'(val);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input int unsigned c, input int unsigned k,
                             input int unsigned l, input int unsigned s);
        // finish a partial item unless the new size makes it restart
        if (tb_fill != 0 && saturate(c, MAX_CHANNELS) * saturate(l, MAX_LENGTH) > tb_fill)
            push_samples(item_size() - tb_fill, 1'b0);
        wait_idle();
        set_reg(REG_CHANNELS, c, CC_W);
        set_reg(REG_KERNEL, k, KL_W);
        set_reg(REG_LENGTH, l, IL_W);
        set_reg(REG_STRIDE, s, WS_W);
        cur_c = c;
        cur_k = k;
        cur_l = l;
        cur_s = s;
        if (tb_fill >= item_size())
            tb_fill = 0;
    endtask

    task automatic run_phase(input int unsigned batches);
        int unsigned total;
        total = item_size();
        if (saturate(cur_k, MAX_KERNEL) <= saturate(cur_l, MAX_LENGTH))
            ensure_weights();
        repeat (batches)
        begin
            repeat ($urandom_range(0, 2)) write_random_weight();
            push_samples(total - tb_fill, 1'b1);
        end
        // leave a broken item behind now and then
        if (total > 1 && $urandom_range(0, 5) == 0)
            push_samples($urandom_range(1, total - 1), 1'b1);
    endtask

    initial
    begin : stimulus
        int unsigned sel;
        int unsigned c;
        int unsigned k;
        int unsigned l;
        int unsigned s;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        burst      = 1'b0;
        items_sent = 0;
        tb_fill    = 0;
        cur_c      = 1;
        cur_k      = 1;
        cur_l      = 16;
        cur_s      = 1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting, extreme weight and samples
        write_weight(0, 0, 0, 16'h8000);
        write_weight(3, 3, 7, 16'h7fff);
        for (int i = 0; i < 16; i++)
            push_sample((i % 4 == 0) ? 16'h8000 : (i % 4 == 1) ? 16'h7fff : pick_value());

        // kernel over range and longer than the input: no window fits
        configure(1, 15, 4, 1);
        push_samples(4, 1'b0);

        // zero channels and zero stride, then shrink the item under a partial fill
        configure(0, 1, 3, 0);
        push_samples(2, 1'b0);
        configure(0, 1, 2, 0);
        push_samples(2, 1'b0);

        // most results per item, then the longest kernel with the widest stride
        configure(4, 1, 16, 1);
        run_phase(1);
        configure(1, 8, 31, 15);
        run_phase(2);

        while (items_sent < ITEM_GOAL)
        begin
            c = $urandom_range(1, 2);
            k = $urandom_range(1, 4);
            l = $urandom_range(k, 10);
            s = $urandom_range(1, 4);
            sel = $urandom_range(0, 9);
            case (sel)
                0:
                begin
                    l = $urandom_range(1, 7);
                    k = $urandom_range(l + 1, 15);
                end
                1: c = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 7);
                2:
                begin
                    c = 1;
                    k = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(9, 15);
                    l = $urandom_range(8, 16);
                end
                3:
                begin
                    c = 1;
                    l = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(17, 31);
                end
                4: s = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 15);
                default: ;
            endcase
            configure(c, k, l, s);
            burst = ($urandom_range(0, 3) == 0);
            run_phase((item_size() > 24) ? 1 : $urandom_range(1, 3));
        end

        wait_idle();
        repeat (TAIL) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

endmodule
